// ----- rtl/core/pidl_pkg.sv -----
`default_nettype none

package pidl_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int CMD_W   = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 5;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;
    localparam int RDATA_W = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_INS_AT    = 3'd2,
        CMD_DEL_FRONT = 3'd3,
        CMD_DEL_BACK  = 3'd4,
        CMD_DEL_AT    = 3'd5,
        CMD_READ_AT   = 3'd6
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2
    } t_cell_op;

endpackage

`default_nettype wire

// ----- rtl/core/pidl_cmd_if.sv -----
`default_nettype none

interface pidl_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [pidl_pkg::CMD_W-1:0]   command;
    logic [pidl_pkg::VALUE_W-1:0] value;
    logic [pidl_pkg::POS_W-1:0]   position;

    modport source (output valid, output command, output value, output position,
                    input ready);
    modport sink   (input valid, input command, input value, input position,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/core/pidl_res_if.sv -----
`default_nettype none

interface pidl_res_if;
    logic                         valid;
    logic                         ready;
    logic [pidl_pkg::STAT_W-1:0]  status;
    logic [pidl_pkg::COUNT_W-1:0] entry_count;
    logic [pidl_pkg::RDATA_W-1:0] read_value;

    modport source (output valid, output status, output entry_count,
                    output read_value, input ready);
    modport sink   (input valid, input status, input entry_count,
                    input read_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/pidl_cell.sv -----
`default_nettype none

module pidl_cell #(
    parameter int DATA_WIDTH = pidl_pkg::DATA_WIDTH_DEF,
    parameter int IDX_W      = 4,
    parameter int CELL_IDX   = 0
) (
    input  wire                     i_clk,
    input  wire pidl_pkg::t_cell_op i_op,
    input  wire  [IDX_W-1:0]        i_idx,
    input  wire  [DATA_WIDTH-1:0]   i_new,
    input  wire  [DATA_WIDTH-1:0]   i_left,
    input  wire  [DATA_WIDTH-1:0]   i_right,
    output logic [DATA_WIDTH-1:0]   o_data,
    output logic [DATA_WIDTH-1:0]   o_rd
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_op)
            pidl_pkg::CELL_INS: begin
                if (MY_IDX > i_idx) begin
                    n_data = i_left;
                end else if (MY_IDX == i_idx) begin
                    n_data = i_new;
                end
            end
            pidl_pkg::CELL_DEL: begin
                if (MY_IDX >= i_idx) begin
                    n_data = i_right;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_rd   = (MY_IDX == i_idx) ? r_data : '0;

endmodule

`default_nettype wire

// ----- rtl/core/pidl_ctrl.sv -----
`default_nettype none

module pidl_ctrl #(
    parameter int CAPACITY = pidl_pkg::CAPACITY_DEF,
    parameter int IDX_W    = $clog2(CAPACITY)
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    pidl_cmd_if.sink                           i_cmd,
    pidl_res_if.source                         o_res,
    input  wire  [pidl_pkg::RDATA_W-1:0]       i_rd_word,
    output pidl_pkg::t_cell_op                 o_op,
    output logic [IDX_W-1:0]                   o_idx
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > pidl_pkg::POS_W) ? CNT_W : pidl_pkg::POS_W) + 1;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    logic [CNT_W-1:0]              r_cnt;
    logic [CNT_W-1:0]              n_cnt;
    logic                          r_valid;
    pidl_pkg::t_status             r_status;
    pidl_pkg::t_status             n_status;
    logic [pidl_pkg::COUNT_W-1:0]  r_count;
    logic [pidl_pkg::RDATA_W-1:0]  r_rdata;

    pidl_pkg::t_cmd                w_cmd;
    pidl_pkg::t_cell_op            w_op;
    logic                          w_accept;
    logic                          w_full;
    logic                          w_empty;
    logic                          w_pos_zero;
    logic                          w_ins_pos_ok;
    logic                          w_pos_ok;
    logic                          w_rd_ok;
    logic [CMP_W-1:0]              w_pos_ext;
    logic [CMP_W-1:0]              w_pos_m1;
    logic [CMP_W-1:0]              w_cnt_ext;
    logic [CMP_W-1:0]              w_cnt_m1;
    logic [CMP_W-1:0]              w_next_ext;

    assign w_cmd      = pidl_pkg::t_cmd'(i_cmd.command);
    assign i_cmd.ready = !r_valid || o_res.ready;
    assign w_accept   = i_cmd.valid && i_cmd.ready;

    assign w_full     = (r_cnt == CNT_FULL);
    assign w_empty    = (r_cnt == '0);
    assign w_pos_ext  = CMP_W'(i_cmd.position);
    assign w_pos_m1   = w_pos_ext - CMP_W'(1);
    assign w_cnt_ext  = CMP_W'(r_cnt);
    assign w_cnt_m1   = w_cnt_ext - CMP_W'(1);
    assign w_pos_zero = (i_cmd.position == '0);
    assign w_ins_pos_ok = !w_pos_zero && (w_pos_ext <= w_cnt_ext + CMP_W'(1));
    assign w_pos_ok     = !w_pos_zero && (w_pos_ext <= w_cnt_ext);

    // decode: status, shift operation and target slot
    always_comb begin
        n_status = pidl_pkg::ST_OK;
        w_op     = pidl_pkg::CELL_HOLD;
        o_idx    = '0;
        w_rd_ok  = 1'b0;
        unique case (w_cmd) inside
            pidl_pkg::CMD_INS_FRONT, pidl_pkg::CMD_INS_BACK: begin
                if (w_full) begin
                    n_status = pidl_pkg::ST_FULL;
                end else begin
                    w_op  = pidl_pkg::CELL_INS;
                    o_idx = (w_cmd == pidl_pkg::CMD_INS_BACK) ? w_cnt_ext[IDX_W-1:0] : '0;
                end
            end
            pidl_pkg::CMD_INS_AT: begin
                if (!w_ins_pos_ok) begin
                    n_status = pidl_pkg::ST_BADPOS;
                end else if (w_full) begin
                    n_status = pidl_pkg::ST_FULL;
                end else begin
                    w_op  = pidl_pkg::CELL_INS;
                    o_idx = w_pos_m1[IDX_W-1:0];
                end
            end
            pidl_pkg::CMD_DEL_FRONT, pidl_pkg::CMD_DEL_BACK: begin
                if (w_empty) begin
                    n_status = pidl_pkg::ST_EMPTY;
                end else begin
                    w_op  = pidl_pkg::CELL_DEL;
                    o_idx = (w_cmd == pidl_pkg::CMD_DEL_BACK) ? w_cnt_m1[IDX_W-1:0] : '0;
                end
            end
            pidl_pkg::CMD_DEL_AT: begin
                if (!w_pos_ok) begin
                    n_status = pidl_pkg::ST_BADPOS;
                end else begin
                    w_op  = pidl_pkg::CELL_DEL;
                    o_idx = w_pos_m1[IDX_W-1:0];
                end
            end
            pidl_pkg::CMD_READ_AT: begin
                if (!w_pos_ok) begin
                    n_status = pidl_pkg::ST_BADPOS;
                end else begin
                    w_rd_ok = 1'b1;
                    o_idx   = w_pos_m1[IDX_W-1:0];
                end
            end
            default: ;
        endcase
    end

    assign o_op = w_accept ? w_op : pidl_pkg::CELL_HOLD;

    always_comb begin
        n_cnt = r_cnt;
        case (o_op)
            pidl_pkg::CELL_INS: n_cnt = r_cnt + CNT_W'(1);
            pidl_pkg::CELL_DEL: n_cnt = r_cnt - CNT_W'(1);
            default: ;
        endcase
    end

    assign w_next_ext = CMP_W'(n_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_accept) begin
                r_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_count  <= w_next_ext[pidl_pkg::COUNT_W-1:0];
            r_rdata  <= w_rd_ok ? i_rd_word : '0;
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.status      = r_status;
    assign o_res.entry_count = r_count;
    assign o_res.read_value  = r_rdata;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_FULL)
        else $error("entry count above capacity");

    a_no_ins_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_op == pidl_pkg::CELL_INS) |-> !w_full)
        else $error("shift-in on a full row");

    a_no_del_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_op == pidl_pkg::CELL_DEL) |-> !w_empty)
        else $error("shift-out on an empty row");

    a_ins_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_op == pidl_pkg::CELL_INS) |=> (r_cnt == $past(r_cnt) + CNT_W'(1)))
        else $error("insert did not grow count");

    a_rd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_status != pidl_pkg::ST_OK)) |-> (r_rdata == '0))
        else $error("read word on a failed command");

endmodule

`default_nettype wire

// ----- rtl/core/positional_insert_delete_list.sv -----
// Channel  Dir  Word fields                      Handshake
// i_cmd    in   command, value, position         valid / ready
// o_res    out  status, entry_count, read_value  valid / ready
//
// One command per cycle while i_cmd.ready is high: every cell of the row shifts or
// holds in the same edge, and each word's result is in the output register the cycle after.
// i_cmd.ready stays high while the output register is empty or being drained.
// Synchronous active-low reset empties the list; cell contents are not reset.
// A stalled result holds the input off only while it is not taken.
`default_nettype none

module positional_insert_delete_list #(
    parameter int CAPACITY   = pidl_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = pidl_pkg::DATA_WIDTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    pidl_cmd_if.sink    i_cmd,
    pidl_res_if.source  o_res
);

    localparam int IDX_W = $clog2(CAPACITY);

    pidl_pkg::t_cell_op           w_op;
    logic [IDX_W-1:0]             w_idx;
    logic [DATA_WIDTH-1:0]        w_new;
    logic [DATA_WIDTH-1:0]        w_data [CAPACITY];
    logic [DATA_WIDTH-1:0]        w_rd   [CAPACITY];
    logic [DATA_WIDTH-1:0]        w_rd_or;
    logic [pidl_pkg::RDATA_W-1:0] w_rd_word;

    assign w_new = DATA_WIDTH'(i_cmd.value);

    pidl_ctrl #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .o_res     (o_res),
        .i_rd_word (w_rd_word),
        .o_op      (w_op),
        .o_idx     (w_idx)
    );

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;

        if (k == 0) begin : g_head
            assign w_left = w_new;
        end else begin : g_body
            assign w_left = w_data[k-1];
        end

        if (k == CAPACITY - 1) begin : g_tail
            assign w_right = w_data[k];
        end else begin : g_mid
            assign w_right = w_data[k+1];
        end

        pidl_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_W      (IDX_W),
            .CELL_IDX   (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op),
            .i_idx   (w_idx),
            .i_new   (w_new),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[k]),
            .o_rd    (w_rd[k])
        );
    end

    // only the addressed cell drives a non-zero read word
    always_comb begin
        w_rd_or = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_rd_or = w_rd_or | w_rd[k];
        end
    end

    assign w_rd_word = pidl_pkg::RDATA_W'(w_rd_or);

endmodule

`default_nettype wire
